FILE: rtl/bac_pkg.sv
// ----------------------------------------------------------------------------
// bac_pkg
// Shared constants, stage payload types and letter mapping functions for the
// bigram affine cipher.
// ----------------------------------------------------------------------------
package bac_pkg;

    localparam int unsigned ALPHABET_SIZE = 31;
    localparam int unsigned KEY_W         = 10;
    localparam int unsigned CHAR_W        = 16;
    localparam int unsigned CNT_W         = 2;
    localparam int unsigned LETTER_W      = 11;
    localparam int unsigned IDX_W         = 5;
    localparam int unsigned VAL_W         = 10;
    localparam int unsigned PROD_W        = 20;

    localparam logic [VAL_W-1:0] MODULUS = VAL_W'(ALPHABET_SIZE * ALPHABET_SIZE);

    localparam logic [CHAR_W-1:0] FIRST_LETTER      = 16'h0430;
    localparam logic [CHAR_W-1:0] LAST_LETTER       = 16'h044F;
    localparam logic [CHAR_W-1:0] CODE_YERU         = 16'h044B;
    localparam logic [CHAR_W-1:0] CODE_SOFT         = 16'h044C;
    localparam logic [CHAR_W-1:0] CODE_SHCHA        = 16'h0449;
    localparam logic [CHAR_W-1:0] CODE_SHIFTED_BASE = 16'h0431;

    localparam logic [IDX_W-1:0] IDX_SOFT  = 5'd26;
    localparam logic [IDX_W-1:0] IDX_YERU  = 5'd27;
    localparam logic [IDX_W-1:0] IDX_SHCHA = 5'd25;

    // Reciprocal of 961 scaled by 2^30, exact for every product below 2^20.
    localparam int unsigned      MOD_RECIP_SHIFT = 30;
    localparam logic [20:0]      MOD_RECIP       = 21'd1117318;
    // Reciprocal of 31 scaled by 2^15, exact for every value below 961.
    localparam int unsigned      DIV_RECIP_SHIFT = 15;
    localparam logic [10:0]      DIV_RECIP       = 11'd1058;

    typedef enum logic [1:0] {
        REG_KEY_A     = 2'd0,
        REG_KEY_B     = 2'd1,
        REG_KEY_A_INV = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic              mode;
        logic [CHAR_W-1:0] first_char;
        logic [CHAR_W-1:0] second_char;
        logic [CNT_W-1:0]  char_count;
    } t_in_item;

    typedef struct packed {
        logic              pair;
        logic [PROD_W-1:0] prod;
    } t_prod_stage;

    typedef struct packed {
        logic              pair;
        logic [PROD_W-1:0] prod;
        logic [VAL_W-1:0]  quot;
    } t_quot_stage;

    typedef struct packed {
        logic             pair;
        logic [VAL_W-1:0] res;
    } t_res_stage;

    typedef struct packed {
        logic [CNT_W-1:0]    out_count;
        logic [LETTER_W-1:0] out_second;
        logic [LETTER_W-1:0] out_first;
    } t_out_item;

    function automatic logic letter_ok(input logic [CHAR_W-1:0] c);
        return (c >= FIRST_LETTER) && (c <= LAST_LETTER);
    endfunction

    function automatic logic [IDX_W-1:0] letter_index(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        if (c == CODE_YERU) begin
            d = CHAR_W'(IDX_YERU);
        end else if (c == CODE_SOFT) begin
            d = CHAR_W'(IDX_SOFT);
        end else if (c > CODE_SHCHA) begin
            d = c - CODE_SHIFTED_BASE;
        end else begin
            d = c - FIRST_LETTER;
        end
        return d[IDX_W-1:0];
    endfunction

    function automatic logic [LETTER_W-1:0] index_letter(input logic [IDX_W-1:0] i);
        logic [LETTER_W-1:0] l;
        if (i == IDX_YERU) begin
            l = CODE_YERU[LETTER_W-1:0];
        end else if (i == IDX_SOFT) begin
            l = CODE_SOFT[LETTER_W-1:0];
        end else if (i > IDX_SHCHA) begin
            l = LETTER_W'(i) + CODE_SHIFTED_BASE[LETTER_W-1:0];
        end else begin
            l = LETTER_W'(i) + FIRST_LETTER[LETTER_W-1:0];
        end
        return l;
    endfunction

endpackage

FILE: rtl/bigram_affine_cipher.sv
// ----------------------------------------------------------------------------
// bigram_affine_cipher
// Affine cipher over one or two lowercase Cyrillic letters per beat.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle while the output side is ready, and
// presents the result beat through five register stages: input register, key
// multiply, reduction multiply, remainder subtract, and letter split into the
// output register. Each stage after the input register holds one multiplier or
// constant shift-add. Beats with a letter outside 0x430..0x44F or a count other
// than one or two produce no output beat. Keys are to be written by the user
// through the configuration port only while no beat is in flight; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module bigram_affine_cipher
    import bac_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [KEY_W-1:0]     i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // Fields from bit 0: first_char[15:0], second_char[31:16], char_count[33:32].
    input  logic [39:0]          s_axis_tdata,
    // Fields from bit 0: mode[0].
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // Fields from bit 0: out_first[10:0], out_second[21:11], out_count[23:22].
    output logic [23:0]          m_axis_tdata
);

    logic [KEY_W-1:0] r_key_a, r_key_b, r_key_a_inv;

    t_in_item    r_s0;
    t_prod_stage r_s1, n_s1;
    t_quot_stage r_s2, n_s2;
    t_res_stage  r_s3, n_s3;
    t_out_item   r_out, n_out;
    logic        r_v0, r_v1, r_v2, r_v3, r_vout;
    logic        n_v1;
    logic        en0, en1, en2, en3, en_out;

    assign en_out = !r_vout || m_axis_tready;
    assign en3    = !r_v3 || en_out;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign en0    = !r_v0 || en1;

    assign s_axis_tready = en0;
    assign m_axis_tvalid = r_vout;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_a     <= KEY_W'(1);
            r_key_b     <= '0;
            r_key_a_inv <= KEY_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY_A:     r_key_a     <= i_cfg_data;
                REG_KEY_B:     r_key_b     <= i_cfg_data;
                REG_KEY_A_INV: r_key_a_inv <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // Stage 1: letter indices, operand select and key multiply.
    logic [IDX_W-1:0]  x1, x2;
    logic [VAL_W-1:0]  x_val, t_val, opnd, mul_key, add_key;
    logic [11:0]       t_raw;
    logic              pair, cnt_ok;

    always_comb begin
        pair   = (r_s0.char_count == CNT_W'(2));
        cnt_ok = pair || (r_s0.char_count == CNT_W'(1));
        n_v1   = r_v0 && cnt_ok && letter_ok(r_s0.first_char)
                 && (!pair || letter_ok(r_s0.second_char));
        x1     = letter_index(r_s0.first_char);
        x2     = letter_index(r_s0.second_char);
        if (pair) begin
            x_val = (VAL_W'(x1) << 5) - VAL_W'(x1) + VAL_W'(x2);
        end else begin
            x_val = VAL_W'(x1);
        end
        t_raw = 12'(x_val) + 12'(2 * ALPHABET_SIZE * ALPHABET_SIZE) - 12'(r_key_b);
        if (t_raw >= 12'(2 * ALPHABET_SIZE * ALPHABET_SIZE)) begin
            t_val = VAL_W'(t_raw - 12'(2 * ALPHABET_SIZE * ALPHABET_SIZE));
        end else if (t_raw >= 12'(MODULUS)) begin
            t_val = VAL_W'(t_raw - 12'(MODULUS));
        end else begin
            t_val = t_raw[VAL_W-1:0];
        end
        if (r_s0.mode) begin
            opnd    = t_val;
            mul_key = r_key_a_inv;
            add_key = '0;
        end else begin
            opnd    = x_val;
            mul_key = r_key_a;
            add_key = r_key_b;
        end
        n_s1.pair = pair;
        n_s1.prod = PROD_W'(mul_key) * PROD_W'(opnd) + PROD_W'(add_key);
    end

    // Stage 2: quotient by 961 through the scaled reciprocal.
    logic [40:0] q_full;
    always_comb begin
        q_full    = 41'(r_s1.prod) * 41'(MOD_RECIP);
        n_s2.pair = r_s1.pair;
        n_s2.prod = r_s1.prod;
        n_s2.quot = q_full[MOD_RECIP_SHIFT +: VAL_W];
    end

    // Stage 3: remainder, 961 * q formed as 1024q - 64q + q.
    logic [PROD_W-1:0] qm;
    always_comb begin
        qm = (PROD_W'(r_s2.quot) << 10) - (PROD_W'(r_s2.quot) << 6) + PROD_W'(r_s2.quot);
        n_s3.pair = r_s2.pair;
        n_s3.res  = VAL_W'(r_s2.prod - qm);
    end

    // Stage 4: split into two base-31 digits and map back to letters.
    logic [20:0]      h_full;
    logic [IDX_W-1:0] hi, lo;
    logic [VAL_W-1:0] lo_wide;
    always_comb begin
        h_full  = 21'(r_s3.res) * 21'(DIV_RECIP);
        hi      = h_full[DIV_RECIP_SHIFT +: IDX_W];
        lo_wide = r_s3.res - ((VAL_W'(hi) << 5) - VAL_W'(hi));
        lo      = lo_wide[IDX_W-1:0];
        if (r_s3.pair) begin
            n_out.out_first  = index_letter(hi);
            n_out.out_second = index_letter(lo);
            n_out.out_count  = CNT_W'(2);
        end else begin
            n_out.out_first  = index_letter(lo);
            n_out.out_second = '0;
            n_out.out_count  = CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_vout <= 1'b0;
        end else begin
            if (en0)    r_v0   <= s_axis_tvalid;
            if (en1)    r_v1   <= n_v1;
            if (en2)    r_v2   <= r_v1;
            if (en3)    r_v3   <= r_v2;
            if (en_out) r_vout <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_s0.mode        <= s_axis_tuser;
            r_s0.first_char  <= s_axis_tdata[15:0];
            r_s0.second_char <= s_axis_tdata[31:16];
            r_s0.char_count  <= s_axis_tdata[33:32];
        end
        if (en1)    r_s1  <= n_s1;
        if (en2)    r_s2  <= n_s2;
        if (en3)    r_s3  <= n_s3;
        if (en_out) r_out <= n_out;
    end

endmodule

FILE: tb/sv/cipher_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cipher_result_checker
// Watches the key port and both streams of the bigram affine cipher, predicts
// the letters of every accepted input beat from its own copy of the keys and
// compares each output beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module cipher_result_checker
    import bac_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [KEY_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    // Fields from bit 0: first_char[15:0], second_char[31:16], char_count[33:32].
    input  logic [39:0]      i_in_data,
    // Fields from bit 0: mode[0].
    input  logic             i_in_user,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    // Fields from bit 0: out_first[10:0], out_second[21:11], out_count[23:22].
    input  logic [23:0]      i_out_data,
    output int               o_mismatches,
    output int               o_pending
);

    localparam int unsigned SQUARE = ALPHABET_SIZE * ALPHABET_SIZE;

    logic [KEY_W-1:0] key_mul;
    logic [KEY_W-1:0] key_add;
    logic [KEY_W-1:0] key_mul_inv;
    t_out_item        expected_letters[$];
    int               errors  = 0;
    int               waiting = 0;

    assign o_mismatches = errors;
    assign o_pending    = waiting;

    function automatic bit is_letter(input logic [CHAR_W-1:0] code);
        return code >= FIRST_LETTER && code <= LAST_LETTER;
    endfunction

    function automatic int unsigned cyr_to_index(input logic [CHAR_W-1:0] code);
        int unsigned offset;
        offset = 32'(code) - 32'(FIRST_LETTER);
        if (offset == 28) begin
            return 26;
        end else if (offset == 27) begin
            return 27;
        end else if (offset > 25) begin
            return offset - 1;
        end
        return offset;
    endfunction

    function automatic logic [LETTER_W-1:0] index_to_cyr(input int unsigned idx);
        int unsigned offset;
        if (idx == 26) begin
            offset = 28;
        end else if (idx == 27) begin
            offset = 27;
        end else if (idx > 25) begin
            offset = idx + 1;
        end else begin
            offset = idx;
        end
        return LETTER_W'(FIRST_LETTER + offset);
    endfunction

    // Returns 0 when the beat is dropped by the block.
    function automatic bit cipher_bigram(input t_in_item beat, output t_out_item letters);
        int unsigned x;
        int unsigned y;
        letters = '0;
        if (beat.char_count != 2'd1 && beat.char_count != 2'd2) begin
            return 0;
        end
        if (!is_letter(beat.first_char)) begin
            return 0;
        end
        if (beat.char_count == 2'd2 && !is_letter(beat.second_char)) begin
            return 0;
        end
        if (beat.char_count == 2'd2) begin
            x = ALPHABET_SIZE * cyr_to_index(beat.first_char) + cyr_to_index(beat.second_char);
        end else begin
            x = cyr_to_index(beat.first_char);
        end
        if (!beat.mode) begin
            y = (key_mul * x + key_add) % SQUARE;
        end else begin
            y = (key_mul_inv * ((x + 2 * SQUARE - key_add) % SQUARE)) % SQUARE;
        end
        letters.out_count = beat.char_count;
        if (beat.char_count == 2'd2) begin
            letters.out_first  = index_to_cyr(y / ALPHABET_SIZE);
            letters.out_second = index_to_cyr(y % ALPHABET_SIZE);
        end else begin
            letters.out_first = index_to_cyr(y % ALPHABET_SIZE);
        end
        return 1;
    endfunction

    function automatic void compare_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_in_item  beat;
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            key_mul     = KEY_W'(1);
            key_add     = '0;
            key_mul_inv = KEY_W'(1);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_KEY_A:     key_mul     = i_cfg_data;
                    REG_KEY_B:     key_add     = i_cfg_data;
                    REG_KEY_A_INV: key_mul_inv = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                beat.mode        = i_in_user;
                beat.first_char  = i_in_data[15:0];
                beat.second_char = i_in_data[31:16];
                beat.char_count  = i_in_data[33:32];
                if (cipher_bigram(beat, want)) begin
                    expected_letters.push_back(want);
                end
            end
            if (i_out_valid && i_out_ready) begin
                got = t_out_item'(i_out_data);
                if (expected_letters.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual 0x%0h",
                             $time, i_out_data);
                    errors++;
                end else begin
                    want = expected_letters.pop_front();
                    compare_field("out_first", int'(want.out_first), int'(got.out_first));
                    compare_field("out_second", int'(want.out_second), int'(got.out_second));
                    compare_field("out_count", int'(want.out_count), int'(got.out_count));
                end
            end
            waiting = expected_letters.size();
        end
    end

endmodule

FILE: tb/sv/bigram_affine_cipher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bigram_affine_cipher_tb
// Drives directed and random letter beats through the bigram affine cipher
// under several key sets, with random idling on both streams and one long
// output stall, and reports the verdict of the result checker.
// ----------------------------------------------------------------------------
module bigram_affine_cipher_tb;
    import bac_pkg::*;

    localparam int PIPE_DEPTH    = 5;
    localparam int SETTLE_CYCLES = 2 * PIPE_DEPTH + 2;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 240;
    localparam int KEY_SETS      = 8;
    localparam int BEATS_PER_SET = 205;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_we      = 1'b0;
    logic [1:0]       i_cfg_idx     = REG_KEY_A;
    logic [KEY_W-1:0] i_cfg_data    = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [39:0]      s_axis_tdata  = '0;
    logic             s_axis_tuser  = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [23:0]      m_axis_tdata;

    int mismatches;
    int in_flight;
    bit no_idling   = 1'b0;
    int holds_asked = 0;

    always #6 i_clk = ~i_clk;

    bigram_affine_cipher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    cipher_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_mismatches (mismatches),
        .o_pending    (in_flight)
    );

    task automatic offer_beat(input logic mode, input logic [CHAR_W-1:0] first_char,
                              input logic [CHAR_W-1:0] second_char,
                              input logic [CNT_W-1:0] char_count);
        if (!no_idling && $urandom_range(0, 99) < 15) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, char_count, second_char, first_char};
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic offer_random_beat();
        logic              mode;
        logic [CHAR_W-1:0] first_char;
        logic [CHAR_W-1:0] second_char;
        logic [CNT_W-1:0]  char_count;
        logic [CHAR_W-1:0] outside;
        mode        = 1'($urandom_range(0, 1));
        first_char  = FIRST_LETTER + CHAR_W'($urandom_range(0, 31));
        second_char = FIRST_LETTER + CHAR_W'($urandom_range(0, 31));
        char_count  = ($urandom_range(0, 3) == 0) ? 2'd1 : 2'd2;
        if (char_count == 2'd1) begin
            second_char = CHAR_W'($urandom);
        end
        outside = $urandom_range(0, 1) ? FIRST_LETTER - 1'b1 : LAST_LETTER + 1'b1;
        case ($urandom_range(0, 9))
            0: begin
                first_char  = CHAR_W'($urandom);
                second_char = CHAR_W'($urandom);
                char_count  = CNT_W'($urandom);
            end
            1: begin
                if ($urandom_range(0, 1)) begin
                    first_char = outside;
                end else begin
                    second_char = outside;
                    char_count  = 2'd2;
                end
            end
            default: ;
        endcase
        offer_beat(mode, first_char, second_char, char_count);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (in_flight != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_keys(input int unsigned mul, input int unsigned add,
                             input int unsigned mul_inv);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_KEY_A;
        i_cfg_data <= KEY_W'(mul);
        @(posedge i_clk);
        i_cfg_idx  <= REG_KEY_B;
        i_cfg_data <= KEY_W'(add);
        @(posedge i_clk);
        i_cfg_idx  <= REG_KEY_A_INV;
        i_cfg_data <= KEY_W'(mul_inv);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic offer_corner_pairs();
        offer_beat(1'b0, FIRST_LETTER, FIRST_LETTER, 2'd2);
        offer_beat(1'b1, FIRST_LETTER, FIRST_LETTER, 2'd2);
        offer_beat(1'b0, LAST_LETTER, LAST_LETTER, 2'd2);
        offer_beat(1'b1, LAST_LETTER, LAST_LETTER, 2'd2);
        offer_beat(1'b0, LAST_LETTER, 16'h0000, 2'd1);
        offer_beat(1'b1, FIRST_LETTER, 16'hFFFF, 2'd1);
    endtask

    // The receiver idles at random and serves each requested long hold-off.
    initial begin : receiver
        int holds_served;
        holds_served = 0;
        forever begin
            @(posedge i_clk);
            if (holds_asked != holds_served) begin
                holds_served = holds_asked;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= no_idling || ($urandom_range(0, 99) >= 15);
            end
        end
    end

    initial begin : watchdog
        int stalled_cycles;
        stalled_cycles = 0;
        while (stalled_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stalled_cycles = 0;
            end else begin
                stalled_cycles++;
            end
        end
        $display("bigram_affine_cipher verification failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned mul;
        int unsigned add;
        int unsigned mul_inv;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset keys make the cipher an identity on letter indices.
        offer_corner_pairs();
        offer_beat(1'b0, CODE_SHCHA + 1'b1, CODE_SHCHA, 2'd2);
        offer_beat(1'b1, CODE_YERU, CODE_SOFT, 2'd2);
        offer_beat(1'b0, CODE_SOFT, 16'hFFFF, 2'd1);
        offer_beat(1'b1, CODE_YERU, 16'h0000, 2'd1);
        offer_beat(1'b0, FIRST_LETTER - 1'b1, FIRST_LETTER, 2'd2);
        offer_beat(1'b1, LAST_LETTER, LAST_LETTER + 1'b1, 2'd2);
        offer_beat(1'b0, 16'h0000, FIRST_LETTER, 2'd1);
        offer_beat(1'b1, 16'hFFFF, FIRST_LETTER, 2'd2);
        offer_beat(1'b0, FIRST_LETTER, FIRST_LETTER, 2'd0);
        offer_beat(1'b1, FIRST_LETTER, FIRST_LETTER, 2'd3);
        wait_idle();
        load_keys(1023, 1023, 1023);
        offer_corner_pairs();

        for (int set = 0; set < KEY_SETS; set++) begin
            case (set)
                0: begin mul = 2;   add = 5;   mul_inv = 481; end
                1: begin mul = 960; add = 960; mul_inv = 960; end
                2: begin mul = 0;   add = 0;   mul_inv = 0;   end
                3: begin mul = 3;   add = 700; mul_inv = 641; end
                4: begin mul = 1;   add = 0;   mul_inv = 1;   end
                default: begin
                    mul     = $urandom_range(0, 1023);
                    add     = $urandom_range(0, 1023);
                    mul_inv = $urandom_range(0, 1023);
                end
            endcase
            wait_idle();
            load_keys(mul, add, mul_inv);
            no_idling = (set == 3);
            for (int n = 0; n < BEATS_PER_SET; n++) begin
                if (set == 5 && n == 40) begin
                    holds_asked++;
                end
                offer_random_beat();
            end
        end
        no_idling = 1'b0;
        wait_idle();

        if (mismatches == 0) begin
            $display("bigram_affine_cipher verification clean");
        end else begin
            $display("bigram_affine_cipher verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/bac_pkg.sv
rtl/bigram_affine_cipher.sv
tb/sv/cipher_result_checker.sv
tb/sv/bigram_affine_cipher_tb.sv
